@@ hdl/modular_polynomial_multiply_macros.svh @@
// Assertion macros for the modular polynomial multiply block.
`ifndef MODULAR_POLYNOMIAL_MULTIPLY_MACROS_SVH
`define MODULAR_POLYNOMIAL_MULTIPLY_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define MPM_ASSERT_IMP(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
	else $error("mpm: same-cycle check failed");
// next-cycle implication
`define MPM_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
	else $error("mpm: next-cycle check failed");
`else
`define MPM_ASSERT_IMP(label, clk, rst_n, cond, prop)
`define MPM_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

@@ hdl/mpm_pkg.sv @@
// Shared types and constants for the modular polynomial multiply block.
`default_nettype none
package mpm_pkg;

	// fixed field widths
	localparam int COEF_W = 30;
	localparam int PROD_W = 2 * COEF_W;
	localparam int OP_W   = 3;
	localparam int IDX_W  = 9;
	localparam int STAT_W = 2;

	localparam logic [COEF_W-1:0] MOD_RESET = 30'd1000000007;

	// reducer: one quotient bit per step over the full product width
	localparam int RED_STEPS = PROD_W;
	localparam int RED_CNT_W = $clog2(RED_STEPS + 1);

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR         = 3'd0,
		OP_APPEND_FIRST  = 3'd1,
		OP_APPEND_SECOND = 3'd2,
		OP_MULTIPLY      = 3'd3,
		OP_READ          = 3'd4
	} opcode_t;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

	// memory port controls from the sequencer
	typedef struct packed {
		logic wr_first;
		logic wr_second;
		logic rd_terms;
		logic wr_prod;
		logic rd_prod;
	} mem_ctl_t;

endpackage
`default_nettype wire

@@ hdl/mpm_reduce.sv @@
// Shared bit-serial reducer: remainder of a product-wide word modulo the modulus.
`default_nettype none
module mpm_reduce (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [mpm_pkg::PROD_W-1:0]      dividend,
	input  logic [mpm_pkg::COEF_W-1:0]      modulus,
	output logic                            done,
	output logic [mpm_pkg::COEF_W-1:0]      remainder
);

	logic                             busy_q;
	logic                             done_q;
	logic [mpm_pkg::RED_CNT_W-1:0]    cnt_q;
	logic [mpm_pkg::COEF_W-1:0]       rem_q;
	logic [mpm_pkg::PROD_W-1:0]       div_q;

	logic [mpm_pkg::COEF_W:0]         trial;
	logic [mpm_pkg::COEF_W:0]         diff;
	logic [mpm_pkg::COEF_W-1:0]       rem_next;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		trial    = {rem_q, div_q[mpm_pkg::PROD_W-1]};
		diff     = trial - {1'b0, modulus};
		rem_next = (trial >= {1'b0, modulus}) ? diff[mpm_pkg::COEF_W-1:0]
			: trial[mpm_pkg::COEF_W-1:0];
	end

	// step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= mpm_pkg::RED_CNT_W'(mpm_pkg::RED_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - mpm_pkg::RED_CNT_W'(1);
				if (cnt_q == mpm_pkg::RED_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and dividend shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_next;
			div_q <= {div_q[mpm_pkg::PROD_W-2:0], 1'b0};
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

@@ hdl/mpm_store.sv @@
// Coefficient and product memories with registered read data.
`default_nettype none
module mpm_store #(
	parameter int MAX_TERMS = 256
) (
	input  logic                          clk,
	input  mpm_pkg::mem_ctl_t             ctl,
	input  logic [$clog2(MAX_TERMS)-1:0]  term_waddr,
	input  logic [mpm_pkg::COEF_W-1:0]    term_wdata,
	input  logic [$clog2(MAX_TERMS)-1:0]  first_raddr,
	input  logic [$clog2(MAX_TERMS)-1:0]  second_raddr,
	input  logic [$clog2(2*MAX_TERMS-1)-1:0] prod_waddr,
	input  logic [mpm_pkg::COEF_W-1:0]    prod_wdata,
	input  logic [$clog2(2*MAX_TERMS-1)-1:0] prod_raddr,
	output logic [mpm_pkg::COEF_W-1:0]    first_rdata,
	output logic [mpm_pkg::COEF_W-1:0]    second_rdata,
	output logic [mpm_pkg::COEF_W-1:0]    prod_rdata
);

	localparam int PROD_DEPTH = 2 * MAX_TERMS - 1;

	logic [mpm_pkg::COEF_W-1:0] first_mem  [MAX_TERMS];
	logic [mpm_pkg::COEF_W-1:0] second_mem [MAX_TERMS];
	logic [mpm_pkg::COEF_W-1:0] prod_mem   [PROD_DEPTH];

	// operand stores
	always_ff @(posedge clk) begin
		if (ctl.wr_first) begin
			first_mem[term_waddr] <= term_wdata;
		end
		if (ctl.wr_second) begin
			second_mem[term_waddr] <= term_wdata;
		end
		if (ctl.rd_terms) begin
			first_rdata  <= first_mem[first_raddr];
			second_rdata <= second_mem[second_raddr];
		end
	end

	// product store
	always_ff @(posedge clk) begin
		if (ctl.wr_prod) begin
			prod_mem[prod_waddr] <= prod_wdata;
		end
		if (ctl.rd_prod) begin
			prod_rdata <= prod_mem[prod_raddr];
		end
	end

endmodule
`default_nettype wire

@@ hdl/modular_polynomial_multiply.sv @@
// Top level: command sequencer, modulus register and result register.
// Commands arrive one word at a time and each gives one result word. Clear,
// unused opcodes, a full store and an out-of-range read go straight to the
// result; a read makes one product memory read. In an append the loaded
// value is reduced by the shared bit-serial reducer, one bit of a 60-bit
// dividend per cycle. A multiply walks every result index k and, for each
// pair of terms that lands on k, reads both operand memories, multiplies,
// reduces and accumulates; with either sequence empty it skips the walk.
// A new command is taken only in idle; a finished result waits in the output
// register while the next command runs. The modulus may be rewritten only
// while idle; writes of 0 or 1 are ignored.
`default_nettype none
`include "modular_polynomial_multiply_macros.svh"
module modular_polynomial_multiply #(
	parameter int MAX_TERMS = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [mpm_pkg::OP_W-1:0]      opcode,
	input  logic [mpm_pkg::COEF_W-1:0]    coef_value,
	input  logic [mpm_pkg::IDX_W-1:0]     read_index,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mpm_pkg::COEF_W-1:0]    result_value,
	output logic [mpm_pkg::STAT_W-1:0]    status,
	input  logic                          cfg_write_en,
	input  logic [mpm_pkg::COEF_W-1:0]    cfg_write_data
);

	localparam int AW   = $clog2(MAX_TERMS);
	localparam int CW   = $clog2(MAX_TERMS + 1);
	localparam int PD   = 2 * MAX_TERMS - 1;
	localparam int PW   = $clog2(PD);
	localparam int PCW  = $clog2(PD + 1);
	localparam int IXW  = (PCW > mpm_pkg::IDX_W) ? PCW : mpm_pkg::IDX_W;
	localparam int CWD  = mpm_pkg::COEF_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_APP_RED,
		S_MK,
		S_MRD,
		S_MMUL,
		S_MRED,
		S_DONE
	} state_t;

	state_t                   state_q;
	logic [CWD-1:0]           modulus_q;
	logic [CW-1:0]            fa_q;
	logic [CW-1:0]            sb_q;
	logic [PCW-1:0]           pc_q;
	logic [PW-1:0]            k_q;
	logic [AW-1:0]            i_q;
	logic [AW-1:0]            ihi_q;
	logic [CWD-1:0]           acc_q;
	logic                     sel_second_q;
	logic [CWD-1:0]           pend_value_q;
	logic [mpm_pkg::STAT_W-1:0] pend_status_q;
	logic                     out_valid_q;
	logic [CWD-1:0]           out_value_q;
	logic [mpm_pkg::STAT_W-1:0] out_status_q;

	mpm_pkg::opcode_t         op;
	mpm_pkg::mem_ctl_t        mem_ctl;
	logic                     accept;
	logic                     out_free;
	logic                     idx_ok;
	logic                     first_full;
	logic                     second_full;
	logic [PCW-1:0]           k_ext;
	logic [PCW-1:0]           fa_ext;
	logic [PCW-1:0]           sb_ext;
	logic [PCW-1:0]           i_lo_w;
	logic [PCW-1:0]           i_hi_w;
	logic [PCW-1:0]           j_w;
	logic [PCW-1:0]           pc_next;
	logic                     last_term;
	logic                     last_k;
	logic [CWD:0]             sum;
	logic [CWD:0]             sum_sub;
	logic [CWD-1:0]           nacc;
	logic [mpm_pkg::PROD_W-1:0] mul;
	logic                     red_start;
	logic [mpm_pkg::PROD_W-1:0] red_dividend;
	logic                     red_done;
	logic [CWD-1:0]           red_rem;
	logic [CWD-1:0]           first_rdata;
	logic [CWD-1:0]           second_rdata;
	logic [CWD-1:0]           prod_rdata;
	logic [AW-1:0]            term_waddr;

	// handshake and command decode
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign op       = mpm_pkg::opcode_t'(opcode);
	assign out_free = !out_valid_q || !out_stall;
	assign idx_ok   = IXW'(read_index) < IXW'(pc_q);
	assign first_full  = fa_q >= CW'(MAX_TERMS);
	assign second_full = sb_q >= CW'(MAX_TERMS);

	// index range of the first operand for result index k, the second operand index and the product length
	always_comb begin
		k_ext   = PCW'(k_q);
		fa_ext  = PCW'(fa_q);
		sb_ext  = PCW'(sb_q);
		i_lo_w  = (k_ext >= sb_ext) ? (k_ext - sb_ext + PCW'(1)) : '0;
		i_hi_w  = (k_ext < fa_ext) ? k_ext : (fa_ext - PCW'(1));
		j_w     = k_ext - PCW'(i_q);
		pc_next = fa_ext + sb_ext - PCW'(1);
	end

	assign last_term = (i_q == ihi_q);
	assign last_k    = (PCW'(k_q) + PCW'(1)) == pc_q;

	// modular accumulate: both inputs are below the modulus
	always_comb begin
		sum     = {1'b0, acc_q} + {1'b0, red_rem};
		sum_sub = sum - {1'b0, modulus_q};
		nacc    = (sum >= {1'b0, modulus_q}) ? sum_sub[CWD-1:0] : sum[CWD-1:0];
	end

	// term product, registered inside the reducer
	assign mul = first_rdata * second_rdata;

	assign red_start = (state_q == S_MMUL) || (accept &&
		((op == mpm_pkg::OP_APPEND_FIRST && !first_full) ||
		 (op == mpm_pkg::OP_APPEND_SECOND && !second_full)));
	assign red_dividend = (state_q == S_MMUL) ? mul
		: {{(mpm_pkg::PROD_W - CWD){1'b0}}, coef_value};

	// memory port controls
	always_comb begin
		mem_ctl.wr_first  = (state_q == S_APP_RED) && red_done && !sel_second_q;
		mem_ctl.wr_second = (state_q == S_APP_RED) && red_done && sel_second_q;
		mem_ctl.rd_terms  = (state_q == S_MRD);
		mem_ctl.wr_prod   = (state_q == S_MRED) && red_done && last_term;
		mem_ctl.rd_prod   = accept && (op == mpm_pkg::OP_READ) && idx_ok;
	end

	assign term_waddr = sel_second_q ? sb_q[AW-1:0] : fa_q[AW-1:0];

	mpm_reduce u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (red_start),
		.dividend  (red_dividend),
		.modulus   (modulus_q),
		.done      (red_done),
		.remainder (red_rem)
	);

	mpm_store #(
		.MAX_TERMS (MAX_TERMS)
	) u_store (
		.clk          (clk),
		.ctl          (mem_ctl),
		.term_waddr   (term_waddr),
		.term_wdata   (red_rem),
		.first_raddr  (i_q),
		.second_raddr (j_w[AW-1:0]),
		.prod_waddr   (k_q),
		.prod_wdata   (nacc),
		.prod_raddr   (PW'(read_index)),
		.first_rdata  (first_rdata),
		.second_rdata (second_rdata),
		.prod_rdata   (prod_rdata)
	);

	// modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= mpm_pkg::MOD_RESET;
		end else if (cfg_write_en && (cfg_write_data >= CWD'(2))) begin
			modulus_q <= cfg_write_data;
		end
	end

	// sequencer, counts and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fa_q         <= '0;
			sb_q         <= '0;
			pc_q         <= '0;
			out_valid_q  <= 1'b0;
			out_value_q  <= '0;
			out_status_q <= mpm_pkg::ST_OK;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (op)
							mpm_pkg::OP_CLEAR: begin
								fa_q    <= '0;
								sb_q    <= '0;
								pc_q    <= '0;
								state_q <= S_DONE;
							end
							mpm_pkg::OP_APPEND_FIRST: begin
								state_q <= first_full ? S_DONE : S_APP_RED;
							end
							mpm_pkg::OP_APPEND_SECOND: begin
								state_q <= second_full ? S_DONE : S_APP_RED;
							end
							mpm_pkg::OP_MULTIPLY: begin
								if ((fa_q == '0) || (sb_q == '0)) begin
									pc_q    <= '0;
									state_q <= S_DONE;
								end else begin
									pc_q    <= pc_next;
									state_q <= S_MK;
								end
							end
							mpm_pkg::OP_READ: begin
								state_q <= idx_ok ? S_READ : S_DONE;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_READ: begin
					state_q <= S_DONE;
				end
				S_APP_RED: begin
					if (red_done) begin
						if (sel_second_q) begin
							sb_q <= sb_q + CW'(1);
						end else begin
							fa_q <= fa_q + CW'(1);
						end
						state_q <= S_DONE;
					end
				end
				S_MK: begin
					state_q <= S_MRD;
				end
				S_MRD: begin
					state_q <= S_MMUL;
				end
				S_MMUL: begin
					state_q <= S_MRED;
				end
				S_MRED: begin
					if (red_done) begin
						priority if (last_term && last_k) begin
							state_q <= S_DONE;
						end else if (last_term) begin
							state_q <= S_MK;
						end else begin
							state_q <= S_MRD;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_value_q  <= pend_value_q;
						out_status_q <= pend_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// loop indices, accumulator and pending result
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					sel_second_q  <= (op == mpm_pkg::OP_APPEND_SECOND);
					k_q           <= '0;
					pend_value_q  <= '0;
					pend_status_q <= mpm_pkg::ST_OK;
					if ((op == mpm_pkg::OP_APPEND_FIRST && first_full) ||
						(op == mpm_pkg::OP_APPEND_SECOND && second_full)) begin
						pend_status_q <= mpm_pkg::ST_FULL;
					end
					if (op == mpm_pkg::OP_READ && !idx_ok) begin
						pend_status_q <= mpm_pkg::ST_RANGE;
					end
				end
			end
			S_READ: begin
				pend_value_q <= prod_rdata;
			end
			S_MK: begin
				i_q   <= i_lo_w[AW-1:0];
				ihi_q <= i_hi_w[AW-1:0];
				acc_q <= '0;
			end
			S_MRED: begin
				if (red_done) begin
					if (last_term) begin
						k_q <= k_q + PW'(1);
					end else begin
						acc_q <= nacc;
						i_q   <= i_q + AW'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign result_value = out_value_q;
	assign status       = out_status_q;

	// checks
	`MPM_ASSERT_IMP(a_red_done_owner, clk, arst_n, red_done, (state_q == S_APP_RED) || (state_q == S_MRED))
	`MPM_ASSERT_IMP(a_rem_below_mod, clk, arst_n, red_done, red_rem < modulus_q)
	`MPM_ASSERT_IMP(a_acc_below_mod, clk, arst_n, state_q == S_MRD, acc_q < modulus_q)
	`MPM_ASSERT_NEXT(a_prod_write_next, clk, arst_n, mem_ctl.wr_prod, (state_q == S_MK) || (state_q == S_DONE))

endmodule
`default_nettype wire
